FILE: hw/rtl/bps_pkg.sv
// Shared types and constants for the byte pattern scanner.
package bps_pkg;

    localparam int CFG_IDX_BITS    = 3;
    localparam int ADDR_FIELD_BITS = 48;
    localparam int TOTAL_BITS      = 14;
    localparam int PLEN_BITS       = 6;
    localparam int PAT_WORDS       = 4;
    localparam int PAT_WORD_BITS   = 64;
    localparam int RBUF_DEPTH      = 8;
    localparam int RB_PTR_BITS     = $clog2(RBUF_DEPTH);
    localparam int RB_CNT_BITS     = $clog2(RBUF_DEPTH + 1);

    localparam logic [TOTAL_BITS-1:0] HARD_RESULT_CAP      = TOTAL_BITS'(10000);
    localparam logic [TOTAL_BITS-1:0] DEFAULT_RESULT_LIMIT = TOTAL_BITS'(1000);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PAT0  = 3'd0,
        CFG_PAT1  = 3'd1,
        CFG_PAT2  = 3'd2,
        CFG_PAT3  = 3'd3,
        CFG_LEN   = 3'd4,
        CFG_LIMIT = 3'd5,
        CFG_START = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        RK_MATCH   = 1'b0,
        RK_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [ADDR_FIELD_BITS-1:0] match_address;
        logic [TOTAL_BITS-1:0]      match_total;
        logic                       truncated;
        logic                       run_last;
    } t_result;

    typedef struct packed {
        logic vld_a;
        logic vld_b;
    } t_rb_push;

endpackage

FILE: hw/rtl/byte_pattern_scanner_core.sv
// Top level of the byte pattern scanner: config, cell row, match stage, result queue.
// Timing: an accepted item is registered in the cell row and stage A, and its
//   results in the result queue. Throughput: one item per cycle through the cell
//   row; an end-of-region item that also matches gives two results, handed out in
//   turn. Ready drops when the 8-entry queue cannot hold results of items in flight.
// Reset: config returns to defaults, scan counters and queue clear; window bytes do not.
module byte_pattern_scanner_core import bps_pkg::*; #(
    parameter int MAX_PATTERN_BYTES = 32,
    parameter int ADDRESS_BITS      = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [PAT_WORD_BITS-1:0]   i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_region_end,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_result_kind,
    output logic [ADDR_FIELD_BITS-1:0] o_match_address,
    output logic [TOTAL_BITS-1:0]      o_match_total,
    output logic                       o_truncated,
    output logic                       o_run_last
);

    localparam int NB = MAX_PATTERN_BYTES;
    localparam int LW = $clog2(NB + 1);
    localparam int AB = ADDRESS_BITS;

    // configuration
    logic [PAT_WORD_BITS-1:0]   r_pat [PAT_WORDS];
    logic [PLEN_BITS-1:0]       r_len;
    logic [TOTAL_BITS-1:0]      r_limit;
    logic [ADDR_FIELD_BITS-1:0] r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat[0] <= '0;
            r_pat[1] <= '0;
            r_pat[2] <= '0;
            r_pat[3] <= '0;
            r_len    <= PLEN_BITS'(1);
            r_limit  <= DEFAULT_RESULT_LIMIT;
            r_start  <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PAT0:  r_pat[0] <= i_cfg_data;
                CFG_PAT1:  r_pat[1] <= i_cfg_data;
                CFG_PAT2:  r_pat[2] <= i_cfg_data;
                CFG_PAT3:  r_pat[3] <= i_cfg_data;
                CFG_LEN:   r_len    <= i_cfg_data[PLEN_BITS-1:0];
                CFG_LIMIT: r_limit  <= i_cfg_data[TOTAL_BITS-1:0];
                CFG_START: r_start  <= i_cfg_data[ADDR_FIELD_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pattern aligned to the newest end of the window
    logic [LW-1:0]                   n_len_eff;
    logic [LW-1:0]                   n_shamt;
    logic [PAT_WORDS*PAT_WORD_BITS-1:0] n_pat_vec;
    logic [NB*8-1:0]                 n_pat_lo;
    logic [NB*8-1:0]                 n_align;

    assign n_len_eff = (r_len > PLEN_BITS'(NB)) ? LW'(NB) : LW'(r_len);
    assign n_shamt   = LW'(NB) - n_len_eff;
    assign n_pat_vec = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};
    assign n_pat_lo  = n_pat_vec[NB*8-1:0];
    assign n_align   = n_pat_lo << {n_shamt, 3'b000};

    // cell row, index NB-1 holds the newest byte
    logic          n_in_acc;
    logic [7:0]    w_win [NB];
    logic [NB-1:0] w_ok;

    assign n_in_acc = i_in_valid && o_in_ready;

    for (genvar p = 0; p < NB; p++) begin : g_cell
        logic [7:0] w_src;
        if (p == NB - 1) begin : g_head
            assign w_src = i_data_byte;
        end else begin : g_body
            assign w_src = w_win[p+1];
        end
        bps_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (n_in_acc),
            .i_byte   (w_src),
            .i_pat    (n_align[8*p +: 8]),
            .i_active (LW'(p) >= n_shamt),
            .o_byte   (w_win[p]),
            .o_ok     (w_ok[p])
        );
    end

    // stage A: fill and byte count alongside the shift
    logic [LW-1:0] r_fill;
    logic [AB-1:0] r_seen;
    logic          r_a_vld;
    logic          r_a_last;
    logic          r_a_fill_ok;
    logic [AB-1:0] r_a_seen;
    logic [LW-1:0] n_fill;
    logic [AB-1:0] n_seen;

    assign n_fill = (r_fill == LW'(NB)) ? r_fill : r_fill + LW'(1);
    assign n_seen = r_seen + AB'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_seen  <= '0;
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= n_in_acc;
            if (n_in_acc) begin
                r_fill <= i_region_end ? '0 : n_fill;
                r_seen <= i_region_end ? '0 : n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_acc) begin
            r_a_last    <= i_region_end;
            r_a_fill_ok <= (n_fill >= n_len_eff);
            r_a_seen    <= n_seen;
        end
    end

    // stage B: match decision, counters, results
    logic [TOTAL_BITS-1:0]      r_cnt;
    logic                       r_limh;
    logic                       n_hit;
    logic [TOTAL_BITS-1:0]      n_elim;
    logic [TOTAL_BITS-1:0]      n_cnt_inc;
    logic [TOTAL_BITS-1:0]      n_cnt;
    logic                       n_limh;
    logic [AB+ADDR_FIELD_BITS-1:0] n_start_ext;
    logic [AB-1:0]              n_addr;
    logic [AB+ADDR_FIELD_BITS-1:0] n_addr_ext;
    t_result                    n_res_m;
    t_result                    n_res_s;
    t_rb_push                   n_push;

    assign n_hit = r_a_vld && !r_limh && (n_len_eff != '0) && r_a_fill_ok && (&w_ok);
    assign n_elim = (r_limit == '0) ? TOTAL_BITS'(1) :
                    (r_limit > HARD_RESULT_CAP) ? HARD_RESULT_CAP : r_limit;
    assign n_cnt_inc = r_cnt + TOTAL_BITS'(1);
    assign n_cnt     = n_hit ? n_cnt_inc : r_cnt;
    assign n_limh    = r_limh || (n_hit && (n_cnt_inc >= n_elim));

    assign n_start_ext = {{AB{1'b0}}, r_start};
    assign n_addr      = n_start_ext[AB-1:0] + r_a_seen - AB'(n_len_eff);
    assign n_addr_ext  = {{ADDR_FIELD_BITS{1'b0}}, n_addr};

    always_comb begin
        n_res_m.kind          = RK_MATCH;
        n_res_m.match_address = n_addr_ext[ADDR_FIELD_BITS-1:0];
        n_res_m.match_total   = n_cnt;
        n_res_m.truncated     = n_limh;
        n_res_m.run_last      = !r_a_last;
        n_res_s.kind          = RK_SUMMARY;
        n_res_s.match_address = '0;
        n_res_s.match_total   = n_cnt;
        n_res_s.truncated     = n_limh;
        n_res_s.run_last      = 1'b1;
        n_push.vld_a          = r_a_vld && (n_hit || r_a_last);
        n_push.vld_b          = r_a_vld && n_hit && r_a_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_limh <= 1'b0;
        end else if (r_a_vld) begin
            r_cnt  <= r_a_last ? '0 : n_cnt;
            r_limh <= r_a_last ? 1'b0 : n_limh;
        end
    end

    // result queue
    logic                   w_q_valid;
    t_result                w_q_head;
    logic [RB_CNT_BITS-1:0] w_q_count;
    logic [RB_CNT_BITS:0]   n_need;

    bps_rbuf u_rbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_push),
        .i_res_a (n_hit ? n_res_m : n_res_s),
        .i_res_b (n_res_s),
        .i_pop   (i_out_ready),
        .o_valid (w_q_valid),
        .o_head  (w_q_head),
        .o_count (w_q_count)
    );

    assign n_need     = {1'b0, w_q_count} + (r_a_vld ? (RB_CNT_BITS+1)'(2) : '0);
    assign o_in_ready = (n_need <= (RB_CNT_BITS+1)'(RBUF_DEPTH - 2));

    assign o_out_valid     = w_q_valid;
    assign o_result_kind   = w_q_head.kind;
    assign o_match_address = w_q_head.match_address;
    assign o_match_total   = w_q_head.match_total;
    assign o_truncated     = w_q_head.truncated;
    assign o_run_last      = w_q_head.run_last;

endmodule

FILE: hw/rtl/bps_cell.sv
// One window cell: holds a byte, passes it to the older neighbor, compares it.
module bps_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pat,
    input  logic       i_active,
    output logic [7:0] o_byte,
    output logic       o_ok
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_ok   = !i_active || (r_byte == i_pat);

endmodule

FILE: hw/rtl/bps_rbuf.sv
// Result queue: takes up to two results per cycle, hands out one per cycle while popped.
module bps_rbuf import bps_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_rb_push               i_push,
    input  t_result                i_res_a,
    input  t_result                i_res_b,
    input  logic                   i_pop,
    output logic                   o_valid,
    output t_result                o_head,
    output logic [RB_CNT_BITS-1:0] o_count
);

    t_result                r_mem [RBUF_DEPTH];
    logic [RB_PTR_BITS-1:0] r_wr;
    logic [RB_PTR_BITS-1:0] r_rd;
    logic [RB_CNT_BITS-1:0] r_count;
    logic [RB_PTR_BITS-1:0] n_wr_b;
    logic [RB_CNT_BITS-1:0] n_push;
    logic                   n_pop;

    assign n_wr_b = r_wr + RB_PTR_BITS'(1);
    assign n_push = RB_CNT_BITS'(i_push.vld_a) + RB_CNT_BITS'(i_push.vld_b);
    assign n_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push.vld_a) begin
            r_mem[r_wr] <= i_res_a;
        end
        if (i_push.vld_b) begin
            r_mem[n_wr_b] <= i_res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + n_push[RB_PTR_BITS-1:0];
            r_count <= r_count + n_push - RB_CNT_BITS'(n_pop);
            if (n_pop) begin
                r_rd <= r_rd + RB_PTR_BITS'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;

endmodule

FILE: hw/rtl/bps_checker.sv
// Port-level checks on the scanner's result channel, bound to the top level.
module bps_checker import bps_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_result_kind,
    input logic [ADDR_FIELD_BITS-1:0] o_match_address,
    input logic [TOTAL_BITS-1:0]      o_match_total,
    input logic                       o_truncated,
    input logic                       o_run_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_kind)
        && $stable(o_match_address) && $stable(o_match_total)
        && $stable(o_truncated) && $stable(o_run_last))
        else $error("result item changed while stalled");

    a_summary_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == RK_SUMMARY) |->
        (o_match_address == '0) && o_run_last)
        else $error("summary item malformed");

    a_summary_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && (o_result_kind == RK_MATCH) && !o_run_last |=>
        o_out_valid && (o_result_kind == RK_SUMMARY))
        else $error("summary item missing after final match");

    a_match_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == RK_MATCH) |->
        (o_match_total != '0) && (o_match_total <= HARD_RESULT_CAP))
        else $error("match total out of range");

endmodule

bind byte_pattern_scanner_core bps_checker u_bps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_result_kind   (o_result_kind),
    .o_match_address (o_match_address),
    .o_match_total   (o_match_total),
    .o_truncated     (o_truncated),
    .o_run_last      (o_run_last)
);

FILE: verif/bps_result_checker.sv
// Result checker for the byte pattern scanner: tracks config and scan state, predicts and compares.
`timescale 1ns / 100ps
module bps_result_checker import bps_pkg::*; #(
    parameter int MAX_PATTERN_BYTES = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [PAT_WORD_BITS-1:0]   i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_region_end,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_result_kind,
    input  logic [ADDR_FIELD_BITS-1:0] i_match_address,
    input  logic [TOTAL_BITS-1:0]      i_match_total,
    input  logic                       i_truncated,
    input  logic                       i_run_last,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_item_count,
    output int                         o_match_count,
    output int                         o_summary_count,
    output int                         o_trunc_count
);

    localparam int REPORT_LIMIT = 10;

    logic [PAT_WORD_BITS-1:0]   pat_word [PAT_WORDS];
    logic [PLEN_BITS-1:0]       pat_len;
    logic [TOTAL_BITS-1:0]      hit_limit;
    logic [ADDR_FIELD_BITS-1:0] base_addr;

    logic [7:0]                 window [MAX_PATTERN_BYTES];
    int                         window_fill;
    logic [ADDR_FIELD_BITS-1:0] bytes_taken;
    logic [TOTAL_BITS-1:0]      hits;
    logic                       limit_reached;

    t_result                    due_results [$];
    int fails       = 0;
    int items       = 0;
    int match_items = 0;
    int summaries   = 0;
    int truncs      = 0;

    function automatic logic [7:0] pattern_byte(int k);
        return pat_word[k / 8][(k % 8) * 8 +: 8];
    endfunction

    task automatic clear_scan();
        window_fill   = 0;
        bytes_taken   = '0;
        hits          = '0;
        limit_reached = 1'b0;
    endtask

    task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [PAT_WORD_BITS-1:0] data);
        case (idx)
            CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: pat_word[idx[1:0]] = data;
            CFG_LEN:   pat_len   = data[PLEN_BITS-1:0];
            CFG_LIMIT: hit_limit = data[TOTAL_BITS-1:0];
            CFG_START: base_addr = data[ADDR_FIELD_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic advance_scan(logic [7:0] data, logic at_end);
        int                    len;
        logic [TOTAL_BITS-1:0] cap;
        logic                  hit;
        t_result               r;
        len = (pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pat_len);
        if (hit_limit == '0) begin
            cap = TOTAL_BITS'(1);
        end else if (hit_limit > HARD_RESULT_CAP) begin
            cap = HARD_RESULT_CAP;
        end else begin
            cap = hit_limit;
        end
        if (!limit_reached) begin
            for (int k = 0; k < MAX_PATTERN_BYTES - 1; k++) window[k] = window[k + 1];
            window[MAX_PATTERN_BYTES - 1] = data;
            if (window_fill < MAX_PATTERN_BYTES) window_fill++;
            bytes_taken = bytes_taken + 1'b1;
            // compare only once the window holds len bytes
            hit = (len != 0) && (window_fill >= len);
            for (int k = 0; k < len; k++) begin
                if (window[MAX_PATTERN_BYTES - len + k] != pattern_byte(k)) hit = 1'b0;
            end
            if (hit) begin
                hits = hits + 1'b1;
                if (hits >= cap) limit_reached = 1'b1;
                r.kind          = RK_MATCH;
                r.match_address = base_addr + bytes_taken - ADDR_FIELD_BITS'(len);
                r.match_total   = hits;
                r.truncated     = limit_reached;
                r.run_last      = !at_end;
                due_results.insert(due_results.size(), r);
                match_items++;
            end
        end
        if (at_end) begin
            r.kind          = RK_SUMMARY;
            r.match_address = '0;
            r.match_total   = hits;
            r.truncated     = limit_reached;
            r.run_last      = 1'b1;
            due_results.insert(due_results.size(), r);
            summaries++;
            if (limit_reached) truncs++;
            clear_scan();
        end
    endtask

    task automatic compare_result();
        t_result want;
        if (due_results.size() == 0) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
                $display("[%0t] unexpected result: kind=%0d addr=%h total=%0d trunc=%0b last=%0b",
                         $time, i_result_kind, i_match_address, i_match_total, i_truncated,
                         i_run_last);
            end
        end else begin
            want = due_results.pop_front();
            if (i_result_kind !== want.kind || i_match_address !== want.match_address ||
                    i_match_total !== want.match_total || i_truncated !== want.truncated ||
                    i_run_last !== want.run_last) begin
                fails++;
                if (fails <= REPORT_LIMIT) begin
                    $display("[%0t] mismatch: exp kind=%0d addr=%h total=%0d trunc=%0b last=%0b",
                             $time, want.kind, want.match_address, want.match_total,
                             want.truncated, want.run_last);
                    $display("           got kind=%0d addr=%h total=%0d trunc=%0b last=%0b",
                             i_result_kind, i_match_address, i_match_total, i_truncated,
                             i_run_last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (pat_word[w]) pat_word[w] = '0;
            pat_len   = PLEN_BITS'(1);
            hit_limit = DEFAULT_RESULT_LIMIT;
            base_addr = '0;
            clear_scan();
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready) begin
                items++;
                advance_scan(i_data_byte, i_region_end);
            end
            if (i_out_valid && i_out_ready) compare_result();
        end
        o_pending       <= due_results.size();
        o_fail_count    <= fails;
        o_item_count    <= items;
        o_match_count   <= match_items;
        o_summary_count <= summaries;
        o_trunc_count   <= truncs;
    end

endmodule

FILE: verif/tb.sv
// Testbench top for byte_pattern_scanner_core: config, byte stream, back-pressure and verdict.
`timescale 1ns / 100ps
module tb;
    import bps_pkg::*;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int RANDOM_ITEMS      = 1830;
    localparam int PRESSURE_ITEMS    = 48;
    localparam int HOLD_CYCLES       = 200;
    localparam int SETTLE_CYCLES     = 4;
    localparam int TAIL_CYCLES       = 10;
    localparam int WATCHDOG_LIMIT    = 3000;

    localparam logic [CFG_IDX_BITS-1:0]    CFG_UNUSED = 3'd7;
    localparam logic [ADDR_FIELD_BITS-1:0] TOP_ADDR   = '1;

    typedef enum int {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } t_idle;

    logic                       i_clk        = 1'b0;
    logic                       i_rst_n      = 1'b0;
    logic                       i_cfg_valid  = 1'b0;
    logic [CFG_IDX_BITS-1:0]    i_cfg_index  = CFG_PAT0;
    logic [PAT_WORD_BITS-1:0]   i_cfg_data   = '0;
    logic                       i_in_valid   = 1'b0;
    logic [7:0]                 i_data_byte  = '0;
    logic                       i_region_end = 1'b0;
    logic                       i_out_ready  = 1'b0;
    logic                       o_cfg_ready;
    logic                       o_in_ready;
    logic                       o_out_valid;
    logic                       o_result_kind;
    logic [ADDR_FIELD_BITS-1:0] o_match_address;
    logic [TOTAL_BITS-1:0]      o_match_total;
    logic                       o_truncated;
    logic                       o_run_last;

    int fail_count;
    int pending;
    int item_count;
    int match_count;
    int summary_count;
    int trunc_count;
    int idle_cycles  = 0;
    int random_items = 0;

    t_idle      tx_idle  = IDLE_FULL;
    t_idle      rx_idle  = IDLE_FULL;
    bit         hold_req = 1'b0;
    logic [7:0] pat [MAX_PATTERN_BYTES];
    logic [7:0] alpha [4];
    int         alpha_n;
    logic [7:0] stream_q [$];

    byte_pattern_scanner_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_region_end    (i_region_end),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_match_address (o_match_address),
        .o_match_total   (o_match_total),
        .o_truncated     (o_truncated),
        .o_run_last      (o_run_last)
    );

    bps_result_checker #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_region_end    (i_region_end),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_result_kind   (o_result_kind),
        .i_match_address (o_match_address),
        .i_match_total   (o_match_total),
        .i_truncated     (o_truncated),
        .i_run_last      (o_run_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_item_count    (item_count),
        .o_match_count   (match_count),
        .o_summary_count (summary_count),
        .o_trunc_count   (trunc_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int draw_wait(t_idle mode);
        case (mode)
            IDLE_FULL:   return $urandom_range(0, 15);
            IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
            default:     return 0;
        endcase
    endfunction

    function automatic t_idle pick_idle();
        return t_idle'($urandom_range(0, 2));
    endfunction

    function automatic logic [PAT_WORD_BITS-1:0] pattern_word(int w);
        logic [PAT_WORD_BITS-1:0] v;
        for (int k = 0; k < 8; k++) v[k * 8 +: 8] = pat[w * 8 + k];
        return v;
    endfunction

    task automatic write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [PAT_WORD_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // upper bits of the narrow registers carry junk, the block must drop them
    task automatic load_config(logic [PLEN_BITS-1:0] len, logic [TOTAL_BITS-1:0] limit,
                               logic [ADDR_FIELD_BITS-1:0] start);
        logic [PAT_WORD_BITS-1:0] junk;
        junk = {$urandom, $urandom};
        write_cfg(CFG_PAT0, pattern_word(0));
        write_cfg(CFG_PAT1, pattern_word(1));
        write_cfg(CFG_PAT2, pattern_word(2));
        write_cfg(CFG_PAT3, pattern_word(3));
        write_cfg(CFG_LEN, {junk[PAT_WORD_BITS-1:PLEN_BITS], len});
        write_cfg(CFG_LIMIT, {junk[PAT_WORD_BITS-1:TOTAL_BITS], limit});
        write_cfg(CFG_START, {junk[PAT_WORD_BITS-1:ADDR_FIELD_BITS], start});
        if ($urandom_range(0, 3) == 0) write_cfg(CFG_UNUSED, junk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_item(logic [7:0] data, logic last);
        int gap;
        gap = draw_wait(tx_idle);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= data;
        i_region_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_stream();
        for (int k = 0; k < stream_q.size(); k++) send_item(stream_q[k], k == stream_q.size() - 1);
    endtask

    // drain all results, then allow for items still in the pipe that give none
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int w;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                w = draw_wait(rx_idle);
                if (w > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (w) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                do @(posedge i_clk); while (!o_out_valid && !hold_req);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("byte_pattern_scanner_core regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                         sel;
        int                         plen;
        int                         eff;
        int                         n;
        int                         cut;
        int                         regions;
        int                         phase_no;
        logic [TOTAL_BITS-1:0]      limit;
        logic [ADDR_FIELD_BITS-1:0] start;

        foreach (pat[k]) pat[k] = 8'($urandom);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: single zero byte pattern, two hits, last one on the final item
        send_item(8'h00, 1'b0);
        send_item(8'h5A, 1'b0);
        send_item(8'h00, 1'b1);
        settle();

        // overlapping pattern, limit 0 acts as 1, bytes after truncation ignored
        pat[0] = 8'h01;
        pat[1] = 8'h01;
        load_config(PLEN_BITS'(2), '0, TOP_ADDR);
        repeat (3) send_item(8'h01, 1'b0);
        send_item(8'h01, 1'b1);
        settle();

        // limit reached on the final item, address wraps past the top
        load_config(PLEN_BITS'(2), TOTAL_BITS'(2), TOP_ADDR);
        send_item(8'h01, 1'b0);
        send_item(8'h01, 1'b0);
        send_item(8'h01, 1'b1);
        settle();

        // zero length: summary only
        load_config('0, TOTAL_BITS'(2), '0);
        send_item(8'h01, 1'b0);
        send_item(8'h01, 1'b1);
        settle();

        // limit above the cap, overlapping three byte pattern
        pat[0] = 8'hFF;
        pat[1] = 8'h00;
        pat[2] = 8'hFF;
        load_config(PLEN_BITS'(3), '1, ADDR_FIELD_BITS'({$urandom, $urandom}));
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        settle();

        // back-pressure: output held off while every item matches
        pat[0] = 8'hA5;
        load_config(PLEN_BITS'(1), HARD_RESULT_CAP, '0);
        tx_idle  = IDLE_NONE;
        rx_idle  = IDLE_NONE;
        hold_req = 1'b1;
        stream_q.delete();
        repeat (PRESSURE_ITEMS) stream_q.insert(stream_q.size(), 8'hA5);
        send_stream();
        settle();

        phase_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (phase_no == 0) plen = 63;
            else if (phase_no == 1) plen = MAX_PATTERN_BYTES;
            else if (sel < 50) plen = $urandom_range(1, 4);
            else if (sel < 75) plen = $urandom_range(5, 12);
            else if (sel < 88) plen = $urandom_range(13, 32);
            else if (sel < 94) plen = 0;
            else plen = $urandom_range(33, 63);
            eff = (plen > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : plen;

            alpha_n = $urandom_range(1, 4);
            foreach (alpha[k]) alpha[k] = (phase_no == 1) ? 8'hFF : 8'($urandom);
            for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
                pat[k] = (k < eff) ? alpha[$urandom_range(0, alpha_n - 1)] : 8'($urandom);
            end

            sel = $urandom_range(0, 99);
            if (sel < 35) limit = TOTAL_BITS'($urandom_range(1, 8));
            else if (sel < 65) limit = TOTAL_BITS'($urandom_range(9, 60));
            else if (sel < 75) limit = '0;
            else if (sel < 85) limit = TOTAL_BITS'($urandom_range(10001, 16383));
            else if (sel < 92) limit = HARD_RESULT_CAP;
            else limit = TOTAL_BITS'($urandom_range(61, 9999));

            sel = $urandom_range(0, 99);
            if (sel < 30) start = '0;
            else if (sel < 60) start = TOP_ADDR - ADDR_FIELD_BITS'($urandom_range(0, 40));
            else if (sel < 70) start = TOP_ADDR;
            else start = ADDR_FIELD_BITS'({$urandom, $urandom});

            load_config(PLEN_BITS'(plen), limit, start);
            tx_idle = pick_idle();
            rx_idle = pick_idle();

            regions = $urandom_range(1, 4);
            repeat (regions) begin
                n = $urandom_range(1, 40);
                if ($urandom_range(0, 3) == 0) n += $urandom_range(40, 100);
                if (eff > 8 && $urandom_range(0, 1) == 1) n += eff;
                // whole and partial pattern copies mixed with alphabet bytes and noise
                stream_q.delete();
                while (stream_q.size() < n) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 45 && eff > 0) begin
                        for (int k = 0; k < eff; k++) stream_q.insert(stream_q.size(), pat[k]);
                    end else if (sel < 60 && eff > 1) begin
                        cut = $urandom_range(1, eff - 1);
                        for (int k = 0; k < cut; k++) stream_q.insert(stream_q.size(), pat[k]);
                    end else if (sel < 90) begin
                        stream_q.insert(stream_q.size(), alpha[$urandom_range(0, alpha_n - 1)]);
                    end else begin
                        stream_q.insert(stream_q.size(), 8'($urandom));
                    end
                end
                while (stream_q.size() > n) stream_q.delete(stream_q.size() - 1);
                send_stream();
                random_items += n;
            end
            settle();
            phase_no++;
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d items: directed cases, a held-off output and %0d random configs",
                 item_count, phase_no);
        $display("results seen: %0d matches, %0d end-of-scan, %0d scans cut at the limit",
                 match_count, summary_count, trunc_count);
        if (fail_count == 0 && pending == 0) begin
            $display("byte_pattern_scanner_core regression: pass");
        end else begin
            $display("byte_pattern_scanner_core regression: fail");
        end
        $finish;
    end

endmodule
